// ===== rtl/core/tagged_block_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL
`ifndef TAGGED_BLOCK_ALLOCATOR_DEFINES_SVH
`define TAGGED_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define TBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tba_pkg.sv =====
package tba_pkg;

    // Command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BLOCKS_IN_USE = 1'b0;
    localparam logic CFG_BLOCK_BYTES   = 1'b1;

    localparam int WORD_BITS  = 64;
    localparam int CFG_DATA_W = 25;

    typedef struct packed {
        logic        command;
        logic [63:0] tag_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  block_index;
        logic [31:0] block_offset;
    } t_out_item;

endpackage

// ===== rtl/core/tba_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle
module tba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/tagged_block_allocator.sv =====
// Tagged block allocator. A request (command 0) looks the tag up one slot at a time,
// creates an entry in the lowest free slot if needed (clearing its mask
// row, one word per cycle), then scans the used bitmap one 64-bit word at a time
// for the lowest free block below the block count. A release (command 1)
// walks the tag's mask row word by word, freeing its blocks. The key scan and the
// bitmap word walk go through registered RAM reads, and a result held up at the
// output stalls the sequencer. One item is worked on at a time; the next may be
// accepted while the previous result waits. After reset the used bitmap is
// cleared word by word, during which no item is accepted.
`include "tagged_block_allocator_defines.svh"

module tagged_block_allocator #(
    parameter int NUM_BLOCKS = 256,
    parameter int TAG_SLOTS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [tba_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tba_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tba_pkg::t_out_item        o_out_data
);

    localparam int MAP_WORDS = (NUM_BLOCKS + tba_pkg::WORD_BITS - 1) / tba_pkg::WORD_BITS;
    localparam int MASK_DEPTH = TAG_SLOTS * MAP_WORDS;
    localparam int WW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SW  = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int MAW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
    localparam int BNW = WW + 6;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_KRD, S_KCMP, S_RRD, S_RWR, S_CLR, S_SRD, S_SCHK, S_MUL, S_OUT
    } t_state;

    t_state            r_state;
    logic [8:0]        r_bin;
    logic [24:0]       r_bbytes;
    logic              r_cmd;
    logic [63:0]       r_tag;
    logic [SW-1:0]     r_sidx;
    logic [SW-1:0]     r_slot;
    logic [SW-1:0]     r_free;
    logic              r_free_ok;
    logic [WW-1:0]     r_widx;
    logic [BNW-1:0]    r_blk;
    logic [TAG_SLOTS-1:0] r_tvalid;
    tba_pkg::t_out_item r_res;
    tba_pkg::t_out_item r_odata;
    logic              r_ovalid;

    // RAM ports
    logic              key_we;
    logic [63:0]       key_rdata;
    logic              used_we;
    logic [63:0]       used_wdata, used_rdata;
    logic              mask_we;
    logic [63:0]       mask_wdata, mask_rdata;
    logic [MAW-1:0]    mask_addr;

    // Scan helpers
    logic [31:0]       limit, wbase, rem;
    logic [63:0]       lim_mask, avail, grant_bit;
    logic [5:0]        pos;
    logic              hit, w_last, s_last, scan_end;
    logic              cur_free_ok;
    logic [SW-1:0]     cur_free;

    tba_ram #(.WIDTH(64), .DEPTH(TAG_SLOTS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(cur_free), .i_wdata(r_tag),
        .i_raddr(r_sidx), .o_rdata(key_rdata)
    );

    tba_ram #(.WIDTH(64), .DEPTH(MAP_WORDS)) u_used_ram (
        .i_clk(i_clk), .i_we(used_we), .i_waddr(r_widx), .i_wdata(used_wdata),
        .i_raddr(r_widx), .o_rdata(used_rdata)
    );

    tba_ram #(.WIDTH(64), .DEPTH(MASK_DEPTH)) u_mask_ram (
        .i_clk(i_clk), .i_we(mask_we), .i_waddr(mask_addr), .i_wdata(mask_wdata),
        .i_raddr(mask_addr), .o_rdata(mask_rdata)
    );

    // Effective block count, saturated to the pool size
    assign limit = ({23'd0, r_bin} > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS) : {23'd0, r_bin};
    assign wbase = 32'({r_widx, 6'd0});
    assign rem   = limit - wbase;
    assign lim_mask = (rem >= 32'd64) ? {64{1'b1}} : ((64'd1 << rem[5:0]) - 64'd1);
    assign avail = ~used_rdata & lim_mask;
    assign grant_bit = 64'd1 << pos;
    assign w_last = (r_widx == WW'(MAP_WORDS - 1));
    assign s_last = (r_sidx == SW'(TAG_SLOTS - 1));
    assign scan_end = w_last || ((wbase + 32'd64) >= limit);
    assign hit = r_tvalid[r_sidx] && (key_rdata == r_tag);
    assign mask_addr = MAW'(32'(r_slot) * 32'(MAP_WORDS) + 32'(r_widx));

    // Lowest free slot seen so far, including the slot under compare
    assign cur_free_ok = r_free_ok || !r_tvalid[r_sidx];
    assign cur_free    = r_free_ok ? r_free : r_sidx;

    // Lowest free block within the word
    always_comb begin
        pos = 6'd0;
        for (int i = 63; i >= 0; i--) begin
            if (avail[i]) pos = 6'(i);
        end
    end

    // RAM write controls
    always_comb begin
        key_we     = (r_state == S_KCMP) && !hit && s_last && (r_cmd == tba_pkg::CMD_REQUEST)
                     && cur_free_ok;
        used_we    = 1'b0;
        used_wdata = 64'd0;
        mask_we    = 1'b0;
        mask_wdata = 64'd0;
        case (r_state)
            S_INIT: begin
                used_we = 1'b1;
            end
            S_RWR: begin
                used_we    = 1'b1;
                used_wdata = used_rdata & ~mask_rdata;
                mask_we    = 1'b1;
            end
            S_CLR: begin
                mask_we = 1'b1;
            end
            S_SCHK: begin
                used_we    = (avail != 64'd0);
                used_wdata = used_rdata | grant_bit;
                mask_we    = (avail != 64'd0);
                mask_wdata = mask_rdata | grant_bit;
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_bin    <= 9'd256;
            r_bbytes <= 25'd65536;
            r_widx   <= '0;
            r_tvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tba_pkg::CFG_BLOCKS_IN_USE: r_bin    <= i_cfg_wdata[8:0];
                    tba_pkg::CFG_BLOCK_BYTES:   r_bbytes <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            // S_OUT reloads the register itself when the held item leaves
            if (r_ovalid && i_out_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_widx <= r_widx + WW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_in_data.command;
                        r_tag     <= i_in_data.tag_id;
                        r_sidx    <= '0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_KRD;
                    end
                end
                S_KRD: begin
                    r_state <= S_KCMP;
                end
                S_KCMP: begin
                    r_widx <= '0;
                    if (!r_tvalid[r_sidx] && !r_free_ok) begin
                        r_free    <= r_sidx;
                        r_free_ok <= 1'b1;
                    end
                    if (hit) begin
                        r_slot <= r_sidx;
                        if (r_cmd == tba_pkg::CMD_RELEASE) begin
                            r_state <= S_RRD;
                        end else if (limit == 32'd0) begin
                            r_res   <= '{tba_pkg::ST_NO_BLOCK, 8'd0, 32'd0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end else if (!s_last) begin
                        r_sidx  <= r_sidx + SW'(1);
                        r_state <= S_KRD;
                    end else if (r_cmd == tba_pkg::CMD_RELEASE) begin
                        r_res   <= '{tba_pkg::ST_UNKNOWN, 8'd0, 32'd0};
                        r_state <= S_OUT;
                    end else if (cur_free_ok) begin
                        r_slot             <= cur_free;
                        r_tvalid[cur_free] <= 1'b1;
                        r_state            <= S_CLR;
                    end else begin
                        r_res   <= '{tba_pkg::ST_FULL, 8'd0, 32'd0};
                        r_state <= S_OUT;
                    end
                end
                S_RRD: begin
                    r_state <= S_RWR;
                end
                S_RWR: begin
                    if (w_last) begin
                        r_tvalid[r_slot] <= 1'b0;
                        r_res            <= '{tba_pkg::ST_OK, 8'd0, 32'd0};
                        r_state          <= S_OUT;
                    end else begin
                        r_widx  <= r_widx + WW'(1);
                        r_state <= S_RRD;
                    end
                end
                S_CLR: begin
                    if (w_last) begin
                        r_widx <= '0;
                        if (limit == 32'd0) begin
                            r_res   <= '{tba_pkg::ST_NO_BLOCK, 8'd0, 32'd0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_widx <= r_widx + WW'(1);
                    end
                end
                S_SRD: begin
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (avail != 64'd0) begin
                        r_blk   <= {r_widx, pos};
                        r_state <= S_MUL;
                    end else if (scan_end) begin
                        r_res   <= '{tba_pkg::ST_NO_BLOCK, 8'd0, 32'd0};
                        r_state <= S_OUT;
                    end else begin
                        r_widx  <= r_widx + WW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_MUL: begin
                    r_res.status       <= tba_pkg::ST_OK;
                    r_res.block_index  <= 8'(32'(r_blk));
                    r_res.block_offset <= 32'(32'(r_blk) * {7'd0, r_bbytes});
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output register to be free
                    if (!r_ovalid || i_out_ready) begin
                        r_odata  <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `TBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready held after accept")
    `TBA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status != tba_pkg::ST_OK), (o_out_data.block_index == 8'd0) && (o_out_data.block_offset == 32'd0), "failed result carries a block")
    `TBA_ASSERT_NEXT(a_grant_mul, i_clk, i_rst_n, (r_state == S_SCHK) && (avail != 64'd0), r_state == S_MUL, "grant did not reach offset stage")
    `TBA_ASSERT_NOW(a_create_free, i_clk, i_rst_n, key_we, !r_tvalid[cur_free], "entry created over a live slot")

endmodule

// ===== sim/tagged_block_allocator_test.sv =====
module tagged_block_allocator_test;

    localparam int NUM_BLOCKS = 256;
    localparam int TAG_SLOTS  = 16;
    localparam int N_RANDOM   = 1150;

    // Scoreboard: own copy of the pool and tag table, queue of expected items
    class alloc_scoreboard;
        bit [NUM_BLOCKS-1:0] used_map;
        bit                  slot_live [TAG_SLOTS];
        bit [63:0]           slot_key  [TAG_SLOTS];
        bit [NUM_BLOCKS-1:0] slot_mask [TAG_SLOTS];
        bit [8:0]            blk_count;
        bit [24:0]           blk_bytes;
        tba_pkg::t_out_item  pending [$];
        int                  n_errors;
        int                  n_checked;

        function new();
            used_map  = '0;
            blk_count = 9'd256;
            blk_bytes = 25'd65536;
            n_errors  = 0;
            n_checked = 0;
            for (int s = 0; s < TAG_SLOTS; s++) begin
                slot_live[s] = 1'b0;
                slot_key[s]  = '0;
                slot_mask[s] = '0;
            end
        endfunction

        function void set_reg(logic idx, bit [24:0] val);
            if (idx == tba_pkg::CFG_BLOCKS_IN_USE) blk_count = val[8:0];
            else blk_bytes = val;
        endfunction

        function int find_tag(bit [63:0] tag);
            for (int s = 0; s < TAG_SLOTS; s++)
                if (slot_live[s] && slot_key[s] == tag) return s;
            return -1;
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int s = 0; s < TAG_SLOTS; s++) n += slot_live[s];
            return n;
        endfunction

        // Apply one accepted item to the model and queue its result
        function void note_item(tba_pkg::t_in_item it);
            tba_pkg::t_out_item r;
            int        s;
            int        lim;
            bit [63:0] prod;
            r = '0;
            s = find_tag(it.tag_id);
            if (it.command == tba_pkg::CMD_RELEASE) begin
                if (s < 0) r.status = tba_pkg::ST_UNKNOWN;
                else begin
                    used_map     &= ~slot_mask[s];
                    slot_mask[s]  = '0;
                    slot_live[s]  = 1'b0;
                    r.status      = tba_pkg::ST_OK;
                end
            end else begin
                if (s < 0) begin
                    for (int k = 0; k < TAG_SLOTS; k++)
                        if (!slot_live[k]) begin
                            s = k;
                            break;
                        end
                    if (s >= 0) begin
                        slot_live[s] = 1'b1;
                        slot_key[s]  = it.tag_id;
                        slot_mask[s] = '0;
                    end
                end
                if (s < 0) r.status = tba_pkg::ST_FULL;
                else begin
                    lim      = (blk_count > NUM_BLOCKS) ? NUM_BLOCKS : blk_count;
                    r.status = tba_pkg::ST_NO_BLOCK;
                    for (int b = 0; b < lim; b++)
                        if (!used_map[b]) begin
                            used_map[b]     = 1'b1;
                            slot_mask[s][b] = 1'b1;
                            prod            = 64'(b) * 64'(blk_bytes);
                            r.status        = tba_pkg::ST_OK;
                            r.block_index   = b[7:0];
                            r.block_offset  = prod[31:0];
                            break;
                        end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(tba_pkg::t_out_item got);
            tba_pkg::t_out_item want;
            n_checked++;
            if (pending.size() == 0) begin
                report("result with nothing expected", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) report("status", got, want);
            if (got.block_index != want.block_index) report("block_index", got, want);
            if (got.block_offset != want.block_offset) report("block_offset", got, want);
        endfunction

        function void report(string what, tba_pkg::t_out_item got, tba_pkg::t_out_item want);
            n_errors++;
            $display("MISMATCH %s: got st=%0d idx=%0d off=%h, want st=%0d idx=%0d off=%h",
                     what, got.status, got.block_index, got.block_offset,
                     want.status, want.block_index, want.block_offset);
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic            i_cfg_idx = 1'b0;
    logic [tba_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    tba_pkg::t_in_item  i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    tba_pkg::t_out_item o_out_data;

    alloc_scoreboard sb = new();
    bit              calm;       // long stretch without idling
    int              n_sent;

    tagged_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS), .TAG_SLOTS(TAG_SLOTS)) u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: random stalls, checked at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        i_out_ready <= calm || ($urandom_range(99) >= 12);
    end

    // Valid stays high from one item to the next unless an idle cycle comes between
    task automatic send_item(logic cmd, logic [63:0] tag);
        tba_pkg::t_in_item it;
        it.command = cmd;
        it.tag_id  = tag;
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic write_reg(logic idx, logic [24:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Tag from a small pool mostly, so lookups hit; wide random now and then
    function automatic logic [63:0] pick_tag();
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return 64'hA5A5_0000_0000_0000 + 64'($urandom_range(23));
    endfunction

    task automatic release_all_live();
        for (int s = 0; s < TAG_SLOTS; s++)
            if (sb.slot_live[s]) send_item(tba_pkg::CMD_RELEASE, sb.slot_key[s]);
    endtask

    initial begin
        int rel_pct;
        calm   = 1'b0;
        n_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme tags, both commands, unknown release, table full
        send_item(tba_pkg::CMD_RELEASE, 64'h0);
        send_item(tba_pkg::CMD_REQUEST, 64'h0);
        send_item(tba_pkg::CMD_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(tba_pkg::CMD_REQUEST, 64'h0);
        for (int k = 1; k < TAG_SLOTS - 1; k++) send_item(tba_pkg::CMD_REQUEST, 64'(k) << 40);
        send_item(tba_pkg::CMD_REQUEST, 64'h1234_5678_9ABC_DEF0);
        send_item(tba_pkg::CMD_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(tba_pkg::CMD_RELEASE, 64'h0);
        send_item(tba_pkg::CMD_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Zero blocks: no block ever free; then saturation above the pool size
        write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'd0);
        write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'h1FF_FFFF);
        send_item(tba_pkg::CMD_REQUEST, 64'h77);
        drain();
        write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'h1FF);
        release_all_live();
        for (int k = 0; k < 3; k++) send_item(tba_pkg::CMD_REQUEST, 64'h77);
        drain();

        // Random phases over several settings; small counts exhaust the pool
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'd4);
                    write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'd1);
                end
                1: begin
                    write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'd1);
                    write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'h100_0000);
                end
                2: begin
                    write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'd256);
                    write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'h1FF_FFFF);
                end
                3: begin
                    write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'd70);
                    write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'($urandom));
                end
                4: begin
                    write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'd200);
                    write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'd65536);
                end
                default: begin
                    write_reg(tba_pkg::CFG_BLOCKS_IN_USE, 25'($urandom_range(511)));
                    write_reg(tba_pkg::CFG_BLOCK_BYTES, 25'($urandom));
                end
            endcase
            calm    = (ph == 2);
            rel_pct = (ph == 2) ? 5 : 30;
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                if ($urandom_range(99) < rel_pct) send_item(tba_pkg::CMD_RELEASE, pick_tag());
                else send_item(tba_pkg::CMD_REQUEST, pick_tag());
            end
            calm = 1'b0;
            drain();
        end

        $display("Covered %0d items, %0d results, over six block count and size settings",
                 n_sent, sb.n_checked);
        $display("with pool exhaustion, full tag table and unknown-tag releases.");
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("tagged_block_allocator_test: done, clean");
        else
            $display("tagged_block_allocator_test: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tagged_block_allocator_test: done, errors");
        $finish;
    end
endmodule
